[design/pva_pkg.sv]
package pva_pkg;

   localparam logic [1:0] KIND_PLAY   = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   localparam logic [2:0] ACT_START  = 3'd0;
   localparam logic [2:0] ACT_STOP   = 3'd1;
   localparam logic [2:0] ACT_QUEUED = 3'd2;
   localparam logic [2:0] ACT_REJECT = 3'd3;
   localparam logic [2:0] ACT_NONE   = 3'd4;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 6;
   localparam logic [CSR_IW-1:0] CSR_MAX_PLAYING = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_QUEUE_MODE  = 2'd1;

   localparam logic [CSR_DW-1:0] MAX_PLAYING_RST = 6'd32;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
   } ent_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD_ITEM,
      OP_INS_START,
      OP_INS_READ,
      OP_INS_STEP,
      OP_INS_PUT,
      OP_CMP_START,
      OP_CMP_READ,
      OP_CMP_STEP,
      OP_CMP_END,
      OP_TAIL_READ,
      OP_STEAL,
      OP_HEAD_READ,
      OP_HEAD_LATCH
   } op_type;

   typedef enum logic {
      LIST_PLAY,
      LIST_WAIT
   } list_type;

   typedef enum logic [1:0] {
      CM_FIRST,
      CM_ALL,
      CM_HEAD
   } cmp_mode_type;

   typedef enum logic [1:0] {
      SRC_ITEM,
      SRC_RDATA,
      SRC_ENT
   } src_type;

   typedef struct packed {
      op_type       op;
      list_type     list;
      cmp_mode_type mode;
      logic         emit;
      logic [2:0]   action;
      src_type      src;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       idx_zero;
      logic       idx_end;
      logic       shift;
      logic       steal;
      logic       play_room;
      logic       wait_room;
      logic       wait_any;
      logic       queue_mode;
      logic       found;
      logic       out_free;
   } sts_type;

endpackage

[design/pva_ifs.sv]
interface pva_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] stream_id;
   logic [7:0]  priority_req;
   modport source (output valid, output kind, output stream_id, output priority_req,
                   input ready);
   modport sink (input valid, input kind, input stream_id, input priority_req,
                 output ready);
endinterface

interface pva_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] stream_id_res;
   logic        last;
   modport source (output valid, output action, output stream_id_res, output last,
                   input ready);
   modport sink (input valid, input action, input stream_id_res, input last,
                 output ready);
endinterface

interface pva_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pva_pkg::CSR_IW-1:0] index;
   logic [pva_pkg::CSR_DW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/pva_ram.sv]
module pva_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/pva_dp.sv]
module pva_dp #(
   parameter int PLAY_SLOTS = 32,
   parameter int WAIT_SLOTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pva_pkg::cmd_type            cmd,
   output pva_pkg::sts_type            sts,
   input  logic [1:0]                  req_kind,
   input  logic [15:0]                 req_stream_id,
   input  logic [7:0]                  req_priority,
   input  logic                        csr_we,
   input  logic [pva_pkg::CSR_IW-1:0] csr_index,
   input  logic [pva_pkg::CSR_DW-1:0] csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_action,
   output logic [15:0]                 rsp_stream_id,
   output logic                        rsp_last
);

   localparam int PAW = (PLAY_SLOTS > 1) ? $clog2(PLAY_SLOTS) : 1;
   localparam int WAW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
   localparam int PCW = $clog2(PLAY_SLOTS + 1);
   localparam int WCW = $clog2(WAIT_SLOTS + 1);
   localparam int XW  = $clog2(((PLAY_SLOTS > WAIT_SLOTS) ? PLAY_SLOTS : WAIT_SLOTS) + 1);
   localparam int LW  = (PCW > pva_pkg::CSR_DW) ? PCW : pva_pkg::CSR_DW;
   localparam int EW  = $bits(pva_pkg::ent_type);

   logic [1:0]                  kind_ff, kind_in;
   logic [15:0]                 id_ff, id_in;
   logic [7:0]                  prio_ff, prio_in;
   pva_pkg::ent_type            ent_ff, ent_in;
   logic [PCW-1:0]              pcnt_ff, pcnt_in;
   logic [WCW-1:0]              wcnt_ff, wcnt_in;
   logic [XW-1:0]               idx_ff, idx_in;
   logic [XW-1:0]               wr_ff, wr_in;
   logic                        drop_ff, drop_in;
   logic [pva_pkg::CSR_DW-1:0] max_ff, max_in;
   logic                        qm_ff, qm_in;
   logic                        ov_ff, ov_in;
   logic [2:0]                  oact_ff, oact_in;
   logic [15:0]                 oid_ff, oid_in;
   logic                        olast_ff, olast_in;

   pva_pkg::ent_type play_rd, wait_rd, cur_rd, wdata;
   logic [EW-1:0]    play_rd_raw, wait_rd_raw;
   logic [XW-1:0]    cur_cnt, idx_m1, rd_idx, wr_idx;
   logic [LW-1:0]    max_x, limit;
   logic             p_re, w_re, p_we, w_we, wr_any, match, shift, is_play, out_free;

   assign play_rd = pva_pkg::ent_type'(play_rd_raw);
   assign wait_rd = pva_pkg::ent_type'(wait_rd_raw);
   assign is_play = (cmd.list == pva_pkg::LIST_PLAY);
   assign cur_rd  = is_play ? play_rd : wait_rd;
   assign cur_cnt = is_play ? XW'(pcnt_ff) : XW'(wcnt_ff);
   assign idx_m1  = idx_ff - XW'(1);
   assign shift   = (ent_ff.prio >= cur_rd.prio);
   assign out_free = !ov_ff || rsp_ready;

   assign max_x = LW'(max_ff);
   always_comb begin
      if (max_x == '0) begin
         limit = LW'(1);
      end else if (max_x > LW'(PLAY_SLOTS)) begin
         limit = LW'(PLAY_SLOTS);
      end else begin
         limit = max_x;
      end
   end

   always_comb begin
      case (cmd.mode)
         pva_pkg::CM_FIRST: match = (cur_rd.id == id_ff) && !drop_ff;
         pva_pkg::CM_ALL:   match = (cur_rd.id == id_ff);
         pva_pkg::CM_HEAD:  match = (idx_ff == '0);
         default:           match = 1'b0;
      endcase
   end

   always_comb begin
      case (cmd.op)
         pva_pkg::OP_INS_READ:  rd_idx = idx_m1;
         pva_pkg::OP_CMP_READ:  rd_idx = idx_ff;
         pva_pkg::OP_TAIL_READ: rd_idx = XW'(pcnt_ff) - XW'(1);
         default:               rd_idx = '0;
      endcase
   end

   assign wr_idx = (cmd.op == pva_pkg::OP_CMP_STEP) ? wr_ff : idx_ff;
   assign wdata  = ((cmd.op == pva_pkg::OP_INS_STEP && shift) ||
                    cmd.op == pva_pkg::OP_CMP_STEP) ? cur_rd : ent_ff;
   assign wr_any = (cmd.op == pva_pkg::OP_INS_STEP) || (cmd.op == pva_pkg::OP_INS_PUT) ||
                   (cmd.op == pva_pkg::OP_CMP_STEP && !match);
   assign p_we   = wr_any && is_play;
   assign w_we   = wr_any && !is_play;
   assign p_re   = (is_play && (cmd.op == pva_pkg::OP_INS_READ ||
                                cmd.op == pva_pkg::OP_CMP_READ)) ||
                   (cmd.op == pva_pkg::OP_TAIL_READ);
   assign w_re   = (!is_play && (cmd.op == pva_pkg::OP_INS_READ ||
                                 cmd.op == pva_pkg::OP_CMP_READ)) ||
                   (cmd.op == pva_pkg::OP_HEAD_READ);

   pva_ram #(.WIDTH(EW), .DEPTH(PLAY_SLOTS)) u_play_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (wr_idx[PAW-1:0]),
      .wdata (wdata),
      .re    (p_re),
      .raddr (rd_idx[PAW-1:0]),
      .rdata (play_rd_raw)
   );

   pva_ram #(.WIDTH(EW), .DEPTH(WAIT_SLOTS)) u_wait_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (wr_idx[WAW-1:0]),
      .wdata (wdata),
      .re    (w_re),
      .raddr (rd_idx[WAW-1:0]),
      .rdata (wait_rd_raw)
   );

   always_comb begin
      kind_in  = kind_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      ent_in   = ent_ff;
      pcnt_in  = pcnt_ff;
      wcnt_in  = wcnt_ff;
      idx_in   = idx_ff;
      wr_in    = wr_ff;
      drop_in  = drop_ff;
      max_in   = max_ff;
      qm_in    = qm_ff;
      ov_in    = ov_ff && !rsp_ready;
      oact_in  = oact_ff;
      oid_in   = oid_ff;
      olast_in = olast_ff;

      case (cmd.op)
         pva_pkg::OP_LOAD_ITEM: begin
            kind_in     = req_kind;
            id_in       = req_stream_id;
            prio_in     = req_priority;
            ent_in.id   = req_stream_id;
            ent_in.prio = req_priority;
         end
         pva_pkg::OP_INS_START: idx_in = cur_cnt;
         pva_pkg::OP_INS_STEP: begin
            if (shift) begin
               idx_in = idx_m1;
            end else if (is_play) begin
               pcnt_in = pcnt_ff + PCW'(1);
            end else begin
               wcnt_in = wcnt_ff + WCW'(1);
            end
         end
         pva_pkg::OP_INS_PUT: begin
            if (is_play) begin
               pcnt_in = pcnt_ff + PCW'(1);
            end else begin
               wcnt_in = wcnt_ff + WCW'(1);
            end
         end
         pva_pkg::OP_CMP_START: begin
            idx_in  = '0;
            wr_in   = '0;
            drop_in = 1'b0;
         end
         pva_pkg::OP_CMP_STEP: begin
            idx_in = idx_ff + XW'(1);
            if (match) begin
               drop_in = 1'b1;
            end else begin
               wr_in = wr_ff + XW'(1);
            end
         end
         pva_pkg::OP_CMP_END: begin
            if (is_play) begin
               pcnt_in = wr_ff[PCW-1:0];
            end else begin
               wcnt_in = wr_ff[WCW-1:0];
            end
         end
         pva_pkg::OP_STEAL:      pcnt_in = pcnt_ff - PCW'(1);
         pva_pkg::OP_HEAD_LATCH: ent_in = wait_rd;
         default: ;
      endcase

      if (cmd.emit) begin
         ov_in    = 1'b1;
         oact_in  = cmd.action;
         olast_in = cmd.last;
         case (cmd.src)
            pva_pkg::SRC_RDATA: oid_in = play_rd.id;
            pva_pkg::SRC_ENT:   oid_in = ent_ff.id;
            default:            oid_in = id_ff;
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            pva_pkg::CSR_MAX_PLAYING: max_in = csr_data;
            pva_pkg::CSR_QUEUE_MODE:  qm_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= '0;
         wcnt_ff <= '0;
         max_ff  <= pva_pkg::MAX_PLAYING_RST;
         qm_ff   <= 1'b1;
         ov_ff   <= 1'b0;
      end else begin
         pcnt_ff <= pcnt_in;
         wcnt_ff <= wcnt_in;
         max_ff  <= max_in;
         qm_ff   <= qm_in;
         ov_ff   <= ov_in;
      end
      kind_ff  <= kind_in;
      id_ff    <= id_in;
      prio_ff  <= prio_in;
      ent_ff   <= ent_in;
      idx_ff   <= idx_in;
      wr_ff    <= wr_in;
      drop_ff  <= drop_in;
      oact_ff  <= oact_in;
      oid_ff   <= oid_in;
      olast_ff <= olast_in;
   end

   assign sts.kind       = kind_ff;
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.idx_end    = (idx_ff == cur_cnt);
   assign sts.shift      = shift;
   assign sts.steal      = (prio_ff >= play_rd.prio);
   assign sts.play_room  = (LW'(pcnt_ff) < limit);
   assign sts.wait_room  = (wcnt_ff < WCW'(WAIT_SLOTS));
   assign sts.wait_any   = (wcnt_ff != '0);
   assign sts.queue_mode = qm_ff;
   assign sts.found      = drop_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid     = ov_ff;
   assign rsp_action    = oact_ff;
   assign rsp_stream_id = oid_ff;
   assign rsp_last      = olast_ff;

endmodule

[design/pva_ctrl.sv]
module pva_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   output logic             req_ready,
   input  pva_pkg::sts_type sts,
   output pva_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TAIL_CHK,
      S_STEAL_INS,
      S_INS_LOOP,
      S_INS_STEP,
      S_CMP_LOOP,
      S_CMP_STEP,
      S_FIN_CHK,
      S_PROMO_LATCH,
      S_PROMO_CMP,
      S_PROMO_INS,
      S_CAN_WAIT,
      S_EMIT
   } state_type;

   state_type              st_ff, st_in, ret_ff, ret_in;
   pva_pkg::list_type      lst_ff, lst_in;
   pva_pkg::cmp_mode_type  mode_ff, mode_in;
   logic [2:0]             fact_ff, fact_in;
   pva_pkg::src_type       fsrc_ff, fsrc_in;

   always_comb begin
      st_in   = st_ff;
      ret_in  = ret_ff;
      lst_in  = lst_ff;
      mode_in = mode_ff;
      fact_in = fact_ff;
      fsrc_in = fsrc_ff;

      cmd        = '0;
      cmd.op     = pva_pkg::OP_IDLE;
      cmd.emit   = 1'b0;
      cmd.action = pva_pkg::ACT_NONE;
      cmd.src    = pva_pkg::SRC_ITEM;
      cmd.last   = 1'b1;

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.op = pva_pkg::OP_LOAD_ITEM;
               st_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            fsrc_in = pva_pkg::SRC_ITEM;
            case (sts.kind)
               pva_pkg::KIND_PLAY: begin
                  if (sts.play_room) begin
                     lst_in  = pva_pkg::LIST_PLAY;
                     fact_in = pva_pkg::ACT_START;
                     cmd.op  = pva_pkg::OP_INS_START;
                     st_in   = S_INS_LOOP;
                  end else begin
                     cmd.op = pva_pkg::OP_TAIL_READ;
                     st_in  = S_TAIL_CHK;
                  end
               end
               pva_pkg::KIND_FINISH: begin
                  lst_in  = pva_pkg::LIST_PLAY;
                  mode_in = pva_pkg::CM_FIRST;
                  ret_in  = S_FIN_CHK;
                  cmd.op  = pva_pkg::OP_CMP_START;
                  st_in   = S_CMP_LOOP;
               end
               pva_pkg::KIND_CANCEL: begin
                  lst_in  = pva_pkg::LIST_PLAY;
                  mode_in = pva_pkg::CM_ALL;
                  ret_in  = S_CAN_WAIT;
                  cmd.op  = pva_pkg::OP_CMP_START;
                  st_in   = S_CMP_LOOP;
               end
               default: begin
                  fact_in = pva_pkg::ACT_NONE;
                  st_in   = S_EMIT;
               end
            endcase
         end
         S_TAIL_CHK: begin
            if (sts.steal) begin
               if (sts.out_free) begin
                  cmd.op     = pva_pkg::OP_STEAL;
                  cmd.emit   = 1'b1;
                  cmd.action = pva_pkg::ACT_STOP;
                  cmd.src    = pva_pkg::SRC_RDATA;
                  cmd.last   = 1'b0;
                  st_in      = S_STEAL_INS;
               end
            end else if (sts.queue_mode && sts.wait_room) begin
               lst_in  = pva_pkg::LIST_WAIT;
               fact_in = pva_pkg::ACT_QUEUED;
               cmd.op  = pva_pkg::OP_INS_START;
               st_in   = S_INS_LOOP;
            end else begin
               fact_in = pva_pkg::ACT_REJECT;
               st_in   = S_EMIT;
            end
         end
         S_STEAL_INS: begin
            lst_in  = pva_pkg::LIST_PLAY;
            fact_in = pva_pkg::ACT_START;
            cmd.op  = pva_pkg::OP_INS_START;
            st_in   = S_INS_LOOP;
         end
         S_INS_LOOP: begin
            if (sts.idx_zero) begin
               cmd.op = pva_pkg::OP_INS_PUT;
               st_in  = S_EMIT;
            end else begin
               cmd.op = pva_pkg::OP_INS_READ;
               st_in  = S_INS_STEP;
            end
         end
         S_INS_STEP: begin
            cmd.op = pva_pkg::OP_INS_STEP;
            st_in  = sts.shift ? S_INS_LOOP : S_EMIT;
         end
         S_CMP_LOOP: begin
            if (sts.idx_end) begin
               cmd.op = pva_pkg::OP_CMP_END;
               st_in  = ret_ff;
            end else begin
               cmd.op = pva_pkg::OP_CMP_READ;
               st_in  = S_CMP_STEP;
            end
         end
         S_CMP_STEP: begin
            cmd.op = pva_pkg::OP_CMP_STEP;
            st_in  = S_CMP_LOOP;
         end
         S_FIN_CHK: begin
            if (sts.queue_mode && sts.wait_any && sts.play_room) begin
               cmd.op = pva_pkg::OP_HEAD_READ;
               st_in  = S_PROMO_LATCH;
            end else begin
               fact_in = pva_pkg::ACT_NONE;
               st_in   = S_EMIT;
            end
         end
         S_PROMO_LATCH: begin
            cmd.op = pva_pkg::OP_HEAD_LATCH;
            st_in  = S_PROMO_CMP;
         end
         S_PROMO_CMP: begin
            lst_in  = pva_pkg::LIST_WAIT;
            mode_in = pva_pkg::CM_HEAD;
            ret_in  = S_PROMO_INS;
            cmd.op  = pva_pkg::OP_CMP_START;
            st_in   = S_CMP_LOOP;
         end
         S_PROMO_INS: begin
            lst_in  = pva_pkg::LIST_PLAY;
            fact_in = pva_pkg::ACT_START;
            fsrc_in = pva_pkg::SRC_ENT;
            cmd.op  = pva_pkg::OP_INS_START;
            st_in   = S_INS_LOOP;
         end
         S_CAN_WAIT: begin
            fact_in = sts.found ? pva_pkg::ACT_STOP : pva_pkg::ACT_NONE;
            lst_in  = pva_pkg::LIST_WAIT;
            mode_in = pva_pkg::CM_ALL;
            ret_in  = S_EMIT;
            cmd.op  = pva_pkg::OP_CMP_START;
            st_in   = S_CMP_LOOP;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.action = fact_ff;
               cmd.src    = fsrc_ff;
               st_in      = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      cmd.list = lst_in;
      cmd.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         ret_ff  <= S_IDLE;
         lst_ff  <= pva_pkg::LIST_PLAY;
         mode_ff <= pva_pkg::CM_FIRST;
         fact_ff <= pva_pkg::ACT_NONE;
         fsrc_ff <= pva_pkg::SRC_ITEM;
      end else begin
         st_ff   <= st_in;
         ret_ff  <= ret_in;
         lst_ff  <= lst_in;
         mode_ff <= mode_in;
         fact_ff <= fact_in;
         fsrc_ff <= fsrc_in;
      end
   end

   assign req_ready = (st_ff == S_IDLE);

endmodule

[design/priority_voice_allocator.sv]
// Priority voice allocator: keeps a playing list and a waiting list, each sorted by
// descending priority in its own single-port-read RAM, and answers play, finish and
// cancel words with start/stop/queued/rejected/none results (a steal gives stop then
// start). One word is worked at a time; every list pass reads one entry and then
// handles it in a step state before it reads the next, so the time for a word grows
// with the number of entries scanned in each pass, and a finish with promotion
// scans both lists and then the playing list again.
// The lists need no clearing after reset; the configuration port is always ready.
module priority_voice_allocator #(
   parameter int PLAY_SLOTS = 32,
   parameter int WAIT_SLOTS = 32
) (
   input  logic      clock,
   input  logic      reset,
   pva_req_if.sink   req_ch,
   pva_rsp_if.source rsp_ch,
   pva_csr_if.sink   csr_ch
);

   pva_pkg::cmd_type cmd;
   pva_pkg::sts_type sts;
   logic             req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_ch.valid && req_ready),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pva_dp #(.PLAY_SLOTS(PLAY_SLOTS), .WAIT_SLOTS(WAIT_SLOTS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_kind      (req_ch.kind),
      .req_stream_id (req_ch.stream_id),
      .req_priority  (req_ch.priority_req),
      .csr_we        (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_action    (rsp_ch.action),
      .rsp_stream_id (rsp_ch.stream_id_res),
      .rsp_last      (rsp_ch.last)
   );

endmodule

[design/pva_chk.sv]
module pva_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_action,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_accept_mid_steal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken while a steal is half answered");

   a_only_stop_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_action == pva_pkg::ACT_STOP)
      else $error("non-final result is not a stop");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action <= pva_pkg::ACT_NONE)
      else $error("result action out of range");

endmodule

bind priority_voice_allocator pva_chk u_pva_chk (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_action (rsp_ch.action),
   .rsp_last   (rsp_ch.last)
);

[tb/sv/tb_priority_voice_allocator.sv]
module tb_priority_voice_allocator;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 32;
   localparam int DRAIN_WAIT = 300;

   localparam logic [1:0] K_PLAY  = pva_pkg::KIND_PLAY;
   localparam logic [1:0] K_FIN   = pva_pkg::KIND_FINISH;
   localparam logic [1:0] K_CAN   = pva_pkg::KIND_CANCEL;
   localparam logic [1:0] K_BAD   = 2'd3;
   localparam logic [2:0] A_START = pva_pkg::ACT_START;
   localparam logic [2:0] A_STOP  = pva_pkg::ACT_STOP;
   localparam logic [2:0] A_NONE  = pva_pkg::ACT_NONE;
   localparam logic [1:0] R_MAX   = pva_pkg::CSR_MAX_PLAYING;
   localparam logic [1:0] R_QM    = pva_pkg::CSR_QUEUE_MODE;

   localparam logic [5:0] PHASE_MAX [8] = '{6'd0, 6'd1, 6'd3, 6'd63, 6'd2, 6'd32, 6'd40, 6'd5};
   localparam logic [5:0] PHASE_Q [8]   = '{6'd1, 6'd1, 6'd0, 6'd1, 6'd1, 6'd0, 6'h3F, 6'd1};
   localparam int         PLAY_PCT [8]  = '{85, 80, 60, 70, 50, 60, 55, 65};

   typedef struct {
      logic [2:0]  action;
      logic [15:0] id;
      logic        last;
   } voice_word_type;

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [5:0]  data;
      logic [1:0]  kind;
      logic [15:0] id;
      logic [7:0]  prio;
      bit          has_exp;
      logic [2:0]  exp_act;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pva_req_if req_if ();
   pva_rsp_if rsp_if ();
   pva_csr_if csr_if ();

   priority_voice_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // voice model state
   logic [5:0]  cfg_max;
   logic        cfg_queue;
   logic [15:0] play_id [SLOTS];
   logic [7:0]  play_pr [SLOTS];
   int          play_n;
   logic [15:0] wait_id [SLOTS];
   logic [7:0]  wait_pr [SLOTS];
   int          wait_n;

   voice_word_type pending_results[$];
   stim_row_type   directed[$];
   int             mismatches = 0;
   int             burst_left = 0;

   task automatic sorted_insert(ref logic [15:0] ids[SLOTS], ref logic [7:0] prs[SLOTS],
                                ref int n, input logic [15:0] id, input logic [7:0] prio);
      int pos;
      pos = n;
      if (n >= SLOTS) return;
      for (int i = 0; i < n; i++) begin
         if (prio >= prs[i]) begin
            pos = i;
            break;
         end
      end
      for (int i = n; i > pos; i--) begin
         ids[i] = ids[i-1];
         prs[i] = prs[i-1];
      end
      ids[pos] = id;
      prs[pos] = prio;
      n++;
   endtask

   task automatic remove_at(ref logic [15:0] ids[SLOTS], ref logic [7:0] prs[SLOTS],
                            ref int n, input int pos);
      if (pos >= n) return;
      for (int i = pos; i + 1 < n; i++) begin
         ids[i] = ids[i+1];
         prs[i] = prs[i+1];
      end
      n--;
   endtask

   task automatic remove_id(ref logic [15:0] ids[SLOTS], ref logic [7:0] prs[SLOTS],
                            ref int n, input logic [15:0] id, input bit all,
                            output bit found);
      int i;
      i = 0;
      found = 0;
      while (i < n) begin
         if (ids[i] == id) begin
            remove_at(ids, prs, n, i);
            found = 1;
            if (!all) return;
         end else begin
            i++;
         end
      end
   endtask

   function automatic voice_word_type mk(logic [2:0] a, logic [15:0] id, logic l);
      voice_word_type w;
      w.action = a;
      w.id     = id;
      w.last   = l;
      return w;
   endfunction

   task automatic allocate(input logic [1:0] kind, input logic [15:0] id,
                           input logic [7:0] prio, ref voice_word_type outq[$]);
      int          lim;
      bit          hit;
      bit          wfound;
      logic [15:0] hid;
      logic [7:0]  hpr;
      lim = (cfg_max == 0) ? 1 : (cfg_max > SLOTS) ? SLOTS : cfg_max;
      if (kind == K_PLAY) begin
         if (play_n < lim) begin
            sorted_insert(play_id, play_pr, play_n, id, prio);
            outq = {outq, mk(A_START, id, 1'b1)};
         end else if (prio >= play_pr[play_n-1]) begin
            hid = play_id[play_n-1];
            play_n--;
            sorted_insert(play_id, play_pr, play_n, id, prio);
            outq = {outq, mk(A_STOP, hid, 1'b0)};
            outq = {outq, mk(A_START, id, 1'b1)};
         end else if (cfg_queue && wait_n < SLOTS) begin
            sorted_insert(wait_id, wait_pr, wait_n, id, prio);
            outq = {outq, mk(pva_pkg::ACT_QUEUED, id, 1'b1)};
         end else begin
            outq = {outq, mk(pva_pkg::ACT_REJECT, id, 1'b1)};
         end
      end else if (kind == K_FIN) begin
         remove_id(play_id, play_pr, play_n, id, 1'b0, hit);
         if (cfg_queue && wait_n > 0 && play_n < lim) begin
            hid = wait_id[0];
            hpr = wait_pr[0];
            remove_at(wait_id, wait_pr, wait_n, 0);
            sorted_insert(play_id, play_pr, play_n, hid, hpr);
            outq = {outq, mk(A_START, hid, 1'b1)};
         end else begin
            outq = {outq, mk(A_NONE, id, 1'b1)};
         end
      end else if (kind == K_CAN) begin
         remove_id(play_id, play_pr, play_n, id, 1'b1, hit);
         remove_id(wait_id, wait_pr, wait_n, id, 1'b1, wfound);
         outq = {outq, mk(hit ? A_STOP : A_NONE, id, 1'b1)};
      end else begin
         outq = {outq, mk(A_NONE, id, 1'b1)};
      end
   endtask

   task automatic send_word(input logic [1:0] kind, input logic [15:0] id,
                            input logic [7:0] prio, input bit has_exp,
                            input logic [2:0] exp_act);
      int             gap;
      voice_word_type got[$];
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.stream_id    <= id;
      req_if.priority_req <= prio;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      allocate(kind, id, prio, got);
      if (has_exp) pending_results = {pending_results, mk(exp_act, id, 1'b1)};
      else foreach (got[i]) pending_results = {pending_results, got[i]};
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(negedge clock); while (!csr_if.ready);
      @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == R_MAX) cfg_max = data;
      else if (idx == R_QM) cfg_queue = data[0];
   endtask

   task automatic add_row(bit is_csr, logic [1:0] idx, logic [5:0] data, logic [1:0] kind,
                          logic [15:0] id, logic [7:0] prio, bit has_exp,
                          logic [2:0] exp_act);
      stim_row_type r;
      r.is_csr = is_csr; r.idx = idx; r.data = data; r.kind = kind;
      r.id = id; r.prio = prio; r.has_exp = has_exp; r.exp_act = exp_act;
      directed = {directed, r};
   endtask

   // receiver stall pattern, picked at random from four modes
   int rx_cycle = 0;
   int rx_mode  = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_if.ready <= (rx_cycle % 5) < 2;
         endcase
      end
   end

   always @(negedge clock) begin
      voice_word_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: action %0d id %h last %0d",
                        rsp_if.action, rsp_if.stream_id_res, rsp_if.last);
         end else begin
            e = pending_results[0];
            pending_results.delete(0);
            if (rsp_if.action !== e.action || rsp_if.stream_id_res !== e.id ||
                rsp_if.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp action %0d id %h last %0d, got %0d %h %0d",
                           e.action, e.id, e.last, rsp_if.action,
                           rsp_if.stream_id_res, rsp_if.last);
            end
         end
      end
   end

   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int          r;
      logic [1:0]  k;
      logic [15:0] id;
      logic [7:0]  pr;

      req_if.valid = 1'b0;
      req_if.kind = '0;
      req_if.stream_id = '0;
      req_if.priority_req = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      cfg_max = pva_pkg::MAX_PLAYING_RST;
      cfg_queue = 1'b1;
      play_n = 0;
      wait_n = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(0, R_MAX, 0, K_PLAY,  16'h0000, 8'h00, 1, A_START);
      add_row(0, R_MAX, 0, K_PLAY,  16'hFFFF, 8'hFF, 1, A_START);
      add_row(0, R_MAX, 0, K_BAD,   16'h1234, 8'h55, 1, A_NONE);
      add_row(0, R_MAX, 0, K_CAN,   16'h4321, 8'h00, 1, A_NONE);
      add_row(0, R_MAX, 0, K_FIN,   16'h7777, 8'h00, 1, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0005, 8'h0A, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0005, 8'h0A, 0, A_NONE);
      add_row(0, R_MAX, 0, K_CAN,   16'h0005, 8'h00, 1, A_STOP);
      add_row(1, R_MAX, 6'd1, K_PLAY, 16'h0000, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0009, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h000A, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h000B, 8'hC8, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0014, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_FIN,   16'h000B, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_FIN,   16'hFFFF, 8'h00, 0, A_NONE);
      add_row(1, R_QM, 6'd0, K_PLAY, 16'h0000, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0015, 8'h00, 0, A_NONE);
      add_row(1, R_MAX, 6'd0, K_PLAY, 16'h0000, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0016, 8'hFF, 0, A_NONE);
      add_row(1, R_MAX, 6'd63, K_PLAY, 16'h0000, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_PLAY,  16'h0017, 8'h03, 0, A_NONE);
      add_row(1, R_QM, 6'd1, K_PLAY, 16'h0000, 8'h00, 0, A_NONE);
      add_row(0, R_MAX, 0, K_BAD,   16'hFFFF, 8'hFF, 1, A_NONE);

      foreach (directed[i]) begin
         if (directed[i].is_csr) write_reg(directed[i].idx, directed[i].data);
         else send_word(directed[i].kind, directed[i].id, directed[i].prio,
                        directed[i].has_exp, directed[i].exp_act);
      end

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(R_MAX, PHASE_MAX[ph]);
         write_reg(R_QM, PHASE_Q[ph]);
         for (int n = 0; n < 92; n++) begin
            r = $urandom_range(0, 99);
            if (r < PLAY_PCT[ph]) k = K_PLAY;
            else if (r < PLAY_PCT[ph] + (100 - PLAY_PCT[ph]) / 2) k = K_FIN;
            else if (r < 98) k = K_CAN;
            else k = K_BAD;
            id = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            pr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                             : 8'($urandom_range(0, 255));
            send_word(k, id, pr, 0, A_NONE);
            if (n == 50 && ph % 3 == 0) wait_drained();
         end
      end

      wait_drained();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
